@@ design/smt_pkg.sv @@
// Shared types and constants for the SCCB master transaction unit.
// No dependencies; used by every module of the block.
`default_nettype none

package smt_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } smt_action_e;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_WRITE_LIMIT    = 2'd1,
    CFG_READ_LIMIT     = 2'd2,
    CFG_HOLD_TICKS     = 2'd3
  } smt_cfg_e;

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'd0,
    SQ_ST1   = 4'd1,
    SQ_ADDR1 = 4'd2,
    SQ_AK1   = 4'd3,
    SQ_REG   = 4'd4,
    SQ_AKR   = 4'd5,
    SQ_DATA  = 4'd6,
    SQ_AKD   = 4'd7,
    SQ_ST2   = 4'd8,
    SQ_ADDR2 = 4'd9,
    SQ_AK2   = 4'd10,
    SQ_RECV  = 4'd11,
    SQ_AKO   = 4'd12,
    SQ_PEND  = 4'd13,
    SQ_PMID  = 4'd14,
    SQ_PABT  = 4'd15
  } smt_state_e;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 10;
  localparam int unsigned HoldWidth     = 10;

  localparam logic [7:0]           DeviceAddressRst = 8'd66;
  localparam logic [7:0]           WriteLimitRst    = 8'd20;
  localparam logic [7:0]           ReadLimitRst     = 8'd30;
  localparam logic [HoldWidth-1:0] HoldTicksRst     = 10'd1;

  typedef struct packed {
    logic [7:0]           device_address;
    logic [7:0]           write_attempt_limit;
    logic [7:0]           read_attempt_limit;
    logic [HoldWidth-1:0] hold_ticks;
  } smt_cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic [7:0] read_count;
    logic       sda_sample;
  } smt_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_is_output;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } smt_result_t;

endpackage

`default_nettype wire

@@ design/smt_sequencer.sv @@
// Bus sequencer: advances the SCCB state machine by one tick per accepted transaction.
// Depends on smt_pkg for state, action, configuration and payload types.
`default_nettype none

module smt_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire smt_pkg::smt_item_t item_i,
  input  wire smt_pkg::smt_cfg_t  cfg_i,
  output smt_pkg::smt_result_t    result_o
);

  smt_pkg::smt_state_e state_q, state_d;
  logic [3:0]                   bit_q, bit_d;
  logic [7:0]                   shift_q, shift_d;
  logic [7:0]                   remain_q, remain_d;
  logic [7:0]                   attempt_q, attempt_d;
  logic [smt_pkg::HoldWidth-1:0] delay_q, delay_d;
  logic [7:0]                   reg_q, reg_d;
  logic [7:0]                   val_q, val_d;
  logic [7:0]                   cnt_q, cnt_d;
  logic                         is_read_q, is_read_d;
  logic                         scl_q, scl_d;
  logic                         sda_q, sda_d;

  logic       rd_valid, rd_last, done, fail_status;
  logic [7:0] rd_byte;

  always_comb begin
    logic                         act_enter, act_next, act_fail, act_begin, act_idle;
    logic                         idle_status;
    smt_pkg::smt_state_e          enter_st;
    logic [smt_pkg::HoldWidth-1:0] delay_inc;
    logic [7:0]                   attempt_inc, limit, remain_dec;
    logic                         sda;

    state_d   = state_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    remain_d  = remain_q;
    attempt_d = attempt_q;
    delay_d   = delay_q;
    reg_d     = reg_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    is_read_d = is_read_q;
    scl_d     = scl_q;
    sda_d     = sda_q;

    rd_valid    = 1'b0;
    rd_last     = 1'b0;
    rd_byte     = 8'd0;
    done        = 1'b0;
    fail_status = 1'b0;

    act_enter   = 1'b0;
    act_next    = 1'b0;
    act_fail    = 1'b0;
    act_begin   = 1'b0;
    act_idle    = 1'b0;
    idle_status = 1'b0;
    enter_st    = smt_pkg::SQ_IDLE;
    delay_inc   = delay_q + {{(smt_pkg::HoldWidth-1){1'b0}}, 1'b1};
    attempt_inc = attempt_q + 8'd1;
    limit       = is_read_q ? cfg_i.read_attempt_limit : cfg_i.write_attempt_limit;
    remain_dec  = remain_q - 8'd1;
    sda         = item_i.sda_sample;

    if (accept_i) begin
      if (state_q == smt_pkg::SQ_IDLE) begin
        if (item_i.action == smt_pkg::ACT_WRITE || item_i.action == smt_pkg::ACT_READ) begin
          reg_d     = item_i.register_address;
          val_d     = item_i.write_value;
          cnt_d     = item_i.read_count;
          is_read_d = (item_i.action == smt_pkg::ACT_READ);
          attempt_d = 8'd0;
          limit     = is_read_d ? cfg_i.read_attempt_limit : cfg_i.write_attempt_limit;
          act_begin = 1'b1;
        end
      end else begin
        delay_d = delay_inc;
        if (delay_inc >= cfg_i.hold_ticks) begin
          case (state_q)
            smt_pkg::SQ_ST1, smt_pkg::SQ_ST2: begin
              if (bit_q == 4'd0) begin
                if (!sda) act_fail = 1'b1;
                else      act_next = 1'b1;
              end else if (sda) begin
                act_fail = 1'b1;
              end else if (state_q == smt_pkg::SQ_ST1) begin
                shift_d   = cfg_i.device_address;
                act_enter = 1'b1;
                enter_st  = smt_pkg::SQ_ADDR1;
              end else begin
                shift_d   = cfg_i.device_address + 8'd1;
                act_enter = 1'b1;
                enter_st  = smt_pkg::SQ_ADDR2;
              end
            end
            smt_pkg::SQ_ADDR1, smt_pkg::SQ_REG, smt_pkg::SQ_DATA, smt_pkg::SQ_ADDR2: begin
              if (bit_q != 4'd15) begin
                act_next = 1'b1;
              end else begin
                act_enter = 1'b1;
                case (state_q)
                  smt_pkg::SQ_ADDR1: enter_st = smt_pkg::SQ_AK1;
                  smt_pkg::SQ_REG:   enter_st = smt_pkg::SQ_AKR;
                  smt_pkg::SQ_DATA:  enter_st = smt_pkg::SQ_AKD;
                  default:           enter_st = smt_pkg::SQ_AK2;
                endcase
              end
            end
            smt_pkg::SQ_AK1, smt_pkg::SQ_AKR, smt_pkg::SQ_AKD, smt_pkg::SQ_AK2: begin
              act_enter = 1'b1;
              if (bit_q == 4'd0) begin
                act_enter = 1'b0;
                act_next  = 1'b1;
              end else if (state_q == smt_pkg::SQ_AK1) begin
                if (sda) begin
                  enter_st = smt_pkg::SQ_PABT;
                end else begin
                  shift_d  = reg_q;
                  enter_st = smt_pkg::SQ_REG;
                end
              end else if (state_q == smt_pkg::SQ_AKR) begin
                if (is_read_q) begin
                  enter_st = smt_pkg::SQ_PMID;
                end else begin
                  shift_d  = val_q;
                  enter_st = smt_pkg::SQ_DATA;
                end
              end else if (state_q == smt_pkg::SQ_AKD) begin
                enter_st = smt_pkg::SQ_PEND;
              end else if (sda) begin
                enter_st = smt_pkg::SQ_PABT;
              end else begin
                shift_d  = 8'd0;
                enter_st = (remain_q == 8'd0) ? smt_pkg::SQ_PEND : smt_pkg::SQ_RECV;
              end
            end
            smt_pkg::SQ_RECV: begin
              if (!bit_q[0]) begin
                act_next = 1'b1;
              end else begin
                shift_d = {shift_q[6:0], sda};
                if (bit_q != 4'd15) begin
                  act_next = 1'b1;
                end else begin
                  rd_valid  = 1'b1;
                  rd_byte   = shift_d;
                  rd_last   = (remain_q == 8'd1);
                  act_enter = 1'b1;
                  enter_st  = smt_pkg::SQ_AKO;
                end
              end
            end
            smt_pkg::SQ_AKO: begin
              if (bit_q < 4'd3) begin
                act_next = 1'b1;
              end else begin
                remain_d  = remain_dec;
                shift_d   = 8'd0;
                act_enter = 1'b1;
                enter_st  = (remain_dec == 8'd0) ? smt_pkg::SQ_PEND : smt_pkg::SQ_RECV;
              end
            end
            smt_pkg::SQ_PEND, smt_pkg::SQ_PMID, smt_pkg::SQ_PABT: begin
              if (bit_q < 4'd2) begin
                act_next = 1'b1;
              end else if (state_q == smt_pkg::SQ_PEND) begin
                act_idle = 1'b1;
              end else if (state_q == smt_pkg::SQ_PMID) begin
                act_enter = 1'b1;
                enter_st  = smt_pkg::SQ_ST2;
              end else begin
                act_fail = 1'b1;
              end
            end
            default: begin
              act_idle = 1'b1;
            end
          endcase
        end
      end
    end

    if (act_fail) begin
      attempt_d = attempt_inc;
      if (attempt_inc == limit) begin
        act_idle    = 1'b1;
        idle_status = 1'b1;
      end else begin
        act_begin = 1'b1;
      end
    end

    if (act_begin) begin
      remain_d  = cnt_d;
      act_enter = 1'b1;
      enter_st  = smt_pkg::SQ_ST1;
    end

    if (act_idle) begin
      state_d     = smt_pkg::SQ_IDLE;
      bit_d       = 4'd0;
      delay_d     = '0;
      done        = 1'b1;
      fail_status = idle_status;
    end else if (act_enter || act_next) begin
      if (act_enter) begin
        state_d = enter_st;
        bit_d   = 4'd0;
      end else begin
        bit_d = bit_q + 4'd1;
      end
      delay_d = '0;
      case (state_d)
        smt_pkg::SQ_ST1, smt_pkg::SQ_ST2: begin
          scl_d = 1'b1;
          sda_d = (bit_d == 4'd0);
        end
        smt_pkg::SQ_ADDR1, smt_pkg::SQ_REG, smt_pkg::SQ_DATA, smt_pkg::SQ_ADDR2: begin
          scl_d = bit_d[0];
          sda_d = shift_d[~bit_d[3:1]];
        end
        smt_pkg::SQ_AK1, smt_pkg::SQ_AKR, smt_pkg::SQ_AKD, smt_pkg::SQ_AK2,
        smt_pkg::SQ_RECV: begin
          scl_d = bit_d[0];
        end
        smt_pkg::SQ_AKO: begin
          if (bit_d == 4'd0) begin
            scl_d = 1'b0;
          end else begin
            sda_d = (remain_d == 8'd1);
            scl_d = (bit_d == 4'd2);
          end
        end
        smt_pkg::SQ_PEND, smt_pkg::SQ_PMID, smt_pkg::SQ_PABT: begin
          scl_d = (bit_d != 4'd0);
          sda_d = (bit_d == 4'd2);
        end
        default: begin
          scl_d = scl_q;
        end
      endcase
    end
  end

  always_comb begin
    result_o.scl_level  = scl_d;
    result_o.sda_level  = sda_d;
    result_o.read_byte  = rd_byte;
    result_o.read_valid = rd_valid;
    result_o.read_last  = rd_last;
    result_o.busy_res   = (state_d != smt_pkg::SQ_IDLE);
    result_o.done_res   = done;
    result_o.status     = fail_status;
    case (state_d)
      smt_pkg::SQ_ST1, smt_pkg::SQ_ST2: begin
        result_o.sda_is_output = (bit_d != 4'd0);
      end
      smt_pkg::SQ_AK1, smt_pkg::SQ_AKR, smt_pkg::SQ_AKD, smt_pkg::SQ_AK2,
      smt_pkg::SQ_RECV: begin
        result_o.sda_is_output = 1'b0;
      end
      default: begin
        result_o.sda_is_output = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smt_pkg::SQ_IDLE;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      remain_q  <= 8'd0;
      attempt_q <= 8'd0;
      delay_q   <= '0;
      reg_q     <= 8'd0;
      val_q     <= 8'd0;
      cnt_q     <= 8'd0;
      is_read_q <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else begin
      state_q   <= state_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      remain_q  <= remain_d;
      attempt_q <= attempt_d;
      delay_q   <= delay_d;
      reg_q     <= reg_d;
      val_q     <= val_d;
      cnt_q     <= cnt_d;
      is_read_q <= is_read_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

endmodule

`default_nettype wire

@@ design/smt_out_buffer.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on smt_pkg for the result payload type.
`default_nettype none

module smt_out_buffer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire smt_pkg::smt_result_t data_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output smt_pkg::smt_result_t      out_data_o
);

  smt_pkg::smt_result_t main_q, main_d, skid_q, skid_d;
  logic                 main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;
  logic                 pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ design/sccb_master_transaction_unit.sv @@
// SCCB master transaction unit: one input transaction is one bus tick.
// Each result is registered in the output register, or the skid register if it stalls.
// Throughput: one transaction per cycle while in_stall_o is low; the sequencer state
// updates in one pass; the two-entry buffer keeps taking input while one result waits.
// Reset: sequencer idle, SCL and SDA high, configuration at its default values.
// Depends on smt_pkg, smt_sequencer and smt_out_buffer.
`default_nettype none

module sccb_master_transaction_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire smt_pkg::smt_item_t                   in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output smt_pkg::smt_result_t                      out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [smt_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire logic [smt_pkg::CfgDataWidth-1:0]     cfg_data_i
);

  smt_pkg::smt_cfg_t    cfg_q;
  smt_pkg::smt_result_t result;
  logic                 accept;
  logic                 full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address      <= smt_pkg::DeviceAddressRst;
      cfg_q.write_attempt_limit <= smt_pkg::WriteLimitRst;
      cfg_q.read_attempt_limit  <= smt_pkg::ReadLimitRst;
      cfg_q.hold_ticks          <= smt_pkg::HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        smt_pkg::CFG_DEVICE_ADDRESS: cfg_q.device_address      <= cfg_data_i[7:0];
        smt_pkg::CFG_WRITE_LIMIT:    cfg_q.write_attempt_limit <= cfg_data_i[7:0];
        smt_pkg::CFG_READ_LIMIT:     cfg_q.read_attempt_limit  <= cfg_data_i[7:0];
        smt_pkg::CFG_HOLD_TICKS:     cfg_q.hold_ticks          <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  smt_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  smt_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
